[rtl/btlv_pkg.sv]
`timescale 1ns / 1ps

package btlv_pkg;

    localparam logic [2:0] ROLE_TAG   = 3'd0;
    localparam logic [2:0] ROLE_LEN   = 3'd1;
    localparam logic [2:0] ROLE_VALUE = 3'd2;
    localparam logic [2:0] ROLE_ERROR = 3'd3;
    localparam logic [2:0] ROLE_DISC  = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_INDEF = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;
    localparam logic [1:0] ERR_TRUNC = 2'd3;

    localparam logic [7:0] LEN_INDEF     = 8'h80;
    localparam logic [6:0] MAX_LEN_BYTES = 7'd4;

    typedef enum logic [4:0] {
        PH_TAG     = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_LONG    = 5'b00100,
        PH_VALUE   = 5'b01000,
        PH_DISCARD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  record_tag;
        logic [31:0] value_length;
        logic        header_done;
        logic [7:0]  value_byte;
        logic [31:0] value_index;
        logic        record_done;
        logic [1:0]  fault_kind;
    } result_t;

endpackage

[rtl/btlv_in_if.sv]
`timescale 1ns / 1ps

interface btlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[rtl/btlv_out_if.sv]
`timescale 1ns / 1ps

interface btlv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  record_tag;
    logic [31:0] value_length;
    logic        header_done;
    logic [7:0]  value_byte;
    logic [31:0] value_index;
    logic        record_done;
    logic [1:0]  fault_kind;

    modport source (
        output valid, output byte_role, output record_tag, output value_length,
        output header_done, output value_byte, output value_index,
        output record_done, output fault_kind, input ready
    );
    modport sink (
        input valid, input byte_role, input record_tag, input value_length,
        input header_done, input value_byte, input value_index,
        input record_done, input fault_kind, output ready
    );
endinterface

[rtl/ber_tlv_stream_decoder_core.sv]
// data path: a beat is held in the input register, decoded by the combinational parser and
// loaded into the result register when that register is empty or its result is being taken
// throughput: one byte per cycle, set by the single decode step between the
// input register and the result register, which both advance while the
// output is taken or empty
// reset: rst_n asynchronous active low; parser returns to expect tag, stages empty
`timescale 1ns / 1ps

module ber_tlv_stream_decoder_core
    import btlv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    btlv_in_if.sink    in_ch,
    btlv_out_if.source out_ch
);

    logic     item_valid;
    in_item_t item;
    result_t  result;
    logic     load_ok;
    logic     take;

    assign take = item_valid && load_ok;

    btlv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    btlv_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (result)
    );

    btlv_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .result  (result),
        .load_ok (load_ok),
        .out_ch  (out_ch)
    );

endmodule

[rtl/btlv_in_stage.sv]
`timescale 1ns / 1ps

module btlv_in_stage
    import btlv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    btlv_in_if.sink  in_ch,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ch.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ch.ready)
        begin
            valid_next = in_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.data_byte     <= in_ch.data_byte;
            item_reg.end_of_buffer <= in_ch.end_of_buffer;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/btlv_parser.sv]
`timescale 1ns / 1ps

module btlv_parser
    import btlv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output result_t  result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  held_tag_reg;
    logic [7:0]  held_tag_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [2:0]  len_left_reg;
    logic [2:0]  len_left_next;
    logic [31:0] val_left_reg;
    logic [31:0] val_left_next;
    logic [31:0] val_pos_reg;
    logic [31:0] val_pos_next;
    logic        header_end;
    logic [7:0]  b;
    logic        eob;

    assign b   = item.data_byte;
    assign eob = item.end_of_buffer;

    always_comb
    begin
        result            = '0;
        result.byte_role  = ROLE_DISC;
        result.record_tag = held_tag_reg;
        result.fault_kind = ERR_NONE;
        phase_next        = phase_reg;
        held_tag_next     = held_tag_reg;
        acc_next          = acc_reg;
        len_left_next     = len_left_reg;
        val_left_next     = val_left_reg;
        val_pos_next      = val_pos_reg;
        header_end        = 1'b0;

        case (phase_reg)
            PH_TAG:
            begin
                held_tag_next     = b;
                result.record_tag = b;
                result.byte_role  = ROLE_TAG;
                phase_next        = PH_LEN;
            end
            PH_LEN:
            begin
                result.byte_role = ROLE_LEN;
                if (!b[7])
                begin
                    acc_next   = {24'd0, b};
                    header_end = 1'b1;
                end
                else if (b == LEN_INDEF)
                begin
                    result.fault_kind = ERR_INDEF;
                end
                else if (b[6:0] > MAX_LEN_BYTES)
                begin
                    result.fault_kind = ERR_LONG;
                end
                else
                begin
                    acc_next      = '0;
                    len_left_next = b[2:0];
                    phase_next    = PH_LONG;
                end
            end
            PH_LONG:
            begin
                result.byte_role = ROLE_LEN;
                acc_next         = {acc_reg[23:0], b};
                len_left_next    = len_left_reg - 3'd1;
                if (len_left_next == 3'd0)
                begin
                    header_end = 1'b1;
                end
            end
            PH_VALUE:
            begin
                result.byte_role    = ROLE_VALUE;
                result.value_length = acc_reg;
                result.value_byte   = b;
                result.value_index  = val_pos_reg;
                val_pos_next        = val_pos_reg + 32'd1;
                val_left_next       = val_left_reg - 32'd1;
                if (val_left_next == 32'd0)
                begin
                    result.record_done = 1'b1;
                    phase_next         = PH_TAG;
                end
            end
            default:
            begin
                result.byte_role = ROLE_DISC;
            end
        endcase

        if (header_end)
        begin
            result.header_done  = 1'b1;
            result.value_length = acc_next;
            if (acc_next == 32'd0)
            begin
                result.record_done = 1'b1;
                phase_next         = PH_TAG;
            end
            else
            begin
                val_left_next = acc_next;
                val_pos_next  = '0;
                phase_next    = PH_VALUE;
            end
        end

        if (result.fault_kind == ERR_NONE && eob && result.byte_role != ROLE_DISC
            && !result.record_done)
        begin
            result.fault_kind = ERR_TRUNC;
        end

        if (result.fault_kind != ERR_NONE)
        begin
            result.byte_role    = ROLE_ERROR;
            result.value_length = '0;
            result.header_done  = 1'b0;
            result.value_byte   = '0;
            result.value_index  = '0;
            result.record_done  = 1'b0;
            phase_next          = PH_DISCARD;
        end

        if (eob)
        begin
            phase_next = PH_TAG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG;
            held_tag_reg <= '0;
            acc_reg      <= '0;
            len_left_reg <= '0;
            val_left_reg <= '0;
            val_pos_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            held_tag_reg <= held_tag_next;
            acc_reg      <= acc_next;
            len_left_reg <= len_left_next;
            val_left_reg <= val_left_next;
            val_pos_reg  <= val_pos_next;
        end
    end

    a_eob_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
        take && eob |=> phase_reg == PH_TAG)
        else $error("phase not back to tag after buffer end");

    a_err_role: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ((result.fault_kind != ERR_NONE) == (result.byte_role == ROLE_ERROR)))
        else $error("error code and error role disagree");

    a_err_to_discard: assert property (@(posedge clk) disable iff (!rst_n)
        take && result.byte_role == ROLE_ERROR && !eob |=> phase_reg == PH_DISCARD)
        else $error("error did not enter discard");

    a_value_only_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        take && result.byte_role == ROLE_VALUE |-> phase_reg == PH_VALUE
            && acc_reg != 32'd0)
        else $error("value beat outside value phase");

endmodule

[rtl/btlv_out_stage.sv]
`timescale 1ns / 1ps

module btlv_out_stage
    import btlv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  result_t    result,
    output logic       load_ok,
    btlv_out_if.source out_ch
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ok = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ok)
        begin
            valid_next = take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.byte_role    = result_reg.byte_role;
    assign out_ch.record_tag   = result_reg.record_tag;
    assign out_ch.value_length = result_reg.value_length;
    assign out_ch.header_done  = result_reg.header_done;
    assign out_ch.value_byte   = result_reg.value_byte;
    assign out_ch.value_index  = result_reg.value_index;
    assign out_ch.record_done  = result_reg.record_done;
    assign out_ch.fault_kind   = result_reg.fault_kind;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import btlv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 150;
    localparam int RANDOM_ITEMS = 550;

    logic clk;
    logic rst_n;

    btlv_in_if in_ch ();
    btlv_out_if out_ch ();

    ber_tlv_stream_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // decoder state mirrored by the bench
    phase_t      parse_phase = PH_TAG;
    logic [7:0]  cur_tag = '0;
    logic [31:0] len_accum = '0;
    logic [2:0]  len_bytes_pending = '0;
    logic [31:0] value_remaining = '0;
    logic [31:0] value_offset = '0;

    result_t     expected_results[$];
    result_t     want;
    logic [7:0]  pending_bytes[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int unsigned sent_count = 0;
    bit          quiet_sender = 1'b0;
    bit          quiet_receiver = 1'b0;
    bit          hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int idle_cycles(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // header finished: either the record ends here or the value follows
    function automatic bit start_value();
        if (len_accum == 32'd0)
        begin
            parse_phase = PH_TAG;
            return 1'b1;
        end
        value_remaining = len_accum;
        value_offset = '0;
        parse_phase = PH_VALUE;
        return 1'b0;
    endfunction

    function automatic result_t decode_byte(input logic [7:0] b, input logic eob);
        result_t r;
        r = '0;
        r.byte_role = ROLE_DISC;
        r.record_tag = cur_tag;
        r.fault_kind = ERR_NONE;
        case (parse_phase)
            PH_TAG:
            begin
                cur_tag = b;
                r.record_tag = b;
                r.byte_role = ROLE_TAG;
                parse_phase = PH_LEN;
            end
            PH_LEN:
            begin
                r.byte_role = ROLE_LEN;
                if (!b[7])
                begin
                    len_accum = {24'd0, b};
                    r.header_done = 1'b1;
                    r.value_length = len_accum;
                    r.record_done = start_value();
                end
                else if (b == LEN_INDEF)
                    r.fault_kind = ERR_INDEF;
                else if (b[6:0] > MAX_LEN_BYTES)
                    r.fault_kind = ERR_LONG;
                else
                begin
                    len_accum = '0;
                    len_bytes_pending = b[2:0];
                    parse_phase = PH_LONG;
                end
            end
            PH_LONG:
            begin
                r.byte_role = ROLE_LEN;
                len_accum = {len_accum[23:0], b};
                len_bytes_pending = len_bytes_pending - 3'd1;
                if (len_bytes_pending == 3'd0)
                begin
                    r.header_done = 1'b1;
                    r.value_length = len_accum;
                    r.record_done = start_value();
                end
            end
            PH_VALUE:
            begin
                r.byte_role = ROLE_VALUE;
                r.value_length = len_accum;
                r.value_byte = b;
                r.value_index = value_offset;
                value_offset = value_offset + 32'd1;
                value_remaining = value_remaining - 32'd1;
                if (value_remaining == 32'd0)
                begin
                    r.record_done = 1'b1;
                    parse_phase = PH_TAG;
                end
            end
            default:
            begin
                r.byte_role = ROLE_DISC;
            end
        endcase
        if (r.fault_kind == ERR_NONE && eob && r.byte_role != ROLE_DISC && !r.record_done)
            r.fault_kind = ERR_TRUNC;
        if (r.fault_kind != ERR_NONE)
        begin
            r.byte_role = ROLE_ERROR;
            r.value_length = '0;
            r.header_done = 1'b0;
            r.value_byte = '0;
            r.value_index = '0;
            r.record_done = 1'b0;
            parse_phase = PH_DISCARD;
        end
        if (eob)
            parse_phase = PH_TAG;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, got role %0h",
                         $time, out_ch.byte_role);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("byte_role", want.byte_role, out_ch.byte_role);
                compare_field("record_tag", want.record_tag, out_ch.record_tag);
                compare_field("value_length", want.value_length, out_ch.value_length);
                compare_field("header_done", want.header_done, out_ch.header_done);
                compare_field("value_byte", want.value_byte, out_ch.value_byte);
                compare_field("value_index", want.value_index, out_ch.value_index);
                compare_field("record_done", want.record_done, out_ch.record_done);
                compare_field("fault_kind", want.fault_kind, out_ch.fault_kind);
            end
        end
    end

    // result receiver with random stalls
    initial
    begin : receiver
        int gap;
        out_ch.ready = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            else
                gap = idle_cycles(quiet_receiver);
            if (gap > 0)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                for (int n = 1; n < gap; n++)
                    @(negedge clk);
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = idle_cycles(quiet_sender);
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            for (int n = 1; n < gap; n++)
                @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_buffer <= eob;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(decode_byte(b, eob));
        sent_count++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < pending_bytes.size(); i++)
            send_byte(pending_bytes[i], i == pending_bytes.size() - 1);
        pending_bytes.delete();
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned draw_value_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(0, 6);
        else if (pick < 97)
            return $urandom_range(7, 30);
        return $urandom_range(128, 200);
    endfunction

    task automatic push_record(input int unsigned vlen, input bit long_form);
        int nmin;
        int nbytes;
        nmin = vlen > 32'hffffff ? 4 : vlen > 32'hffff ? 3 : vlen > 32'hff ? 2 : 1;
        pending_bytes.push_back(8'($urandom));
        if (!long_form && vlen < 128)
            pending_bytes.push_back(8'(vlen));
        else
        begin
            nbytes = $urandom_range(4, nmin);
            pending_bytes.push_back(8'h80 | 8'(nbytes));
            for (int i = nbytes - 1; i >= 0; i--)
                pending_bytes.push_back(8'(vlen >> (8 * i)));
        end
        for (int unsigned k = 0; k < vlen; k++)
            pending_bytes.push_back(8'($urandom));
    endtask

    task automatic build_random_buffer();
        int kind;
        int cut;
        kind = $urandom_range(0, 9);
        pending_bytes.delete();
        if (kind <= 5)
        begin
            repeat ($urandom_range(1, 3))
                push_record(draw_value_length(), $urandom_range(0, 9) < 3);
        end
        else if (kind == 6)
        begin
            // cut short at a random point, possibly not at all
            repeat ($urandom_range(1, 3))
                push_record(draw_value_length(), $urandom_range(0, 1));
            cut = $urandom_range(0, pending_bytes.size() - 1);
            repeat (cut) void'(pending_bytes.pop_back());
        end
        else if (kind == 7)
        begin
            // indefinite or over-long length form
            if ($urandom_range(0, 1))
                push_record(draw_value_length(), $urandom_range(0, 1));
            pending_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 3) == 0)
                pending_bytes.push_back(LEN_INDEF);
            else
                pending_bytes.push_back(8'($urandom_range(8'h85, 8'hff)));
            repeat ($urandom_range(0, 5))
                pending_bytes.push_back(8'($urandom));
        end
        else if (kind == 8)
        begin
            // huge four-byte length, buffer ends early
            pending_bytes.push_back(8'($urandom));
            pending_bytes.push_back(8'h84);
            pending_bytes.push_back(8'($urandom_range(1, 255)));
            repeat (3) pending_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 6))
                pending_bytes.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                pending_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic test_well_formed();
        pending_bytes = {8'h00, 8'h00, 8'hff, 8'h02, 8'h00, 8'hff};
        send_buffer();
        pending_bytes = {8'h02, 8'h81, 8'h01, 8'h7f};
        send_buffer();
        pending_bytes = {8'h1f, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00};
        send_buffer();
    endtask

    task automatic test_errors();
        pending_bytes = {8'ha0, LEN_INDEF, 8'h11};
        send_buffer();
        pending_bytes = {8'ha1, 8'hff};
        send_buffer();
        pending_bytes = {8'h05};
        send_buffer();
        pending_bytes = {8'h04, 8'h82, 8'h01};
        send_buffer();
        pending_bytes = {8'h04, 8'h03, 8'haa};
        send_buffer();
    endtask

    task automatic test_backpressure();
        quiet_sender = 1'b1;
        hold_request = 1'b1;
        push_record(30, 1'b0);
        push_record(5, 1'b1);
        send_buffer();
        quiet_sender = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_random_buffers(input int unsigned n_items);
        int unsigned target;
        target = sent_count + n_items;
        while (sent_count < target)
        begin
            quiet_sender = ($urandom_range(0, 4) == 0);
            quiet_receiver = ($urandom_range(0, 4) == 0);
            build_random_buffer();
            send_buffer();
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.end_of_buffer = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_well_formed();
        test_errors();
        wait_results_drained();
        test_backpressure();
        test_random_buffers(RANDOM_ITEMS);

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/btlv_pkg.sv
rtl/btlv_in_if.sv
rtl/btlv_out_if.sv
rtl/btlv_in_stage.sv
rtl/btlv_parser.sv
rtl/btlv_out_stage.sv
rtl/ber_tlv_stream_decoder_core.sv
bench/tb.sv
